FILE: hdl/shd_pkg.sv
package shd_pkg;

  // Sync pair that opens every frame
  localparam logic [7:0] SYNC_FIRST  = 8'hBB;
  localparam logic [7:0] SYNC_SECOND = 8'hCC;

  // Frame geometry: bytes 0..1 sync, 2..44 payload, 45 checksum
  localparam int unsigned FRAME_LEN = 46;
  localparam int unsigned CHAIN_LEN = 43;
  localparam int unsigned CNT_W     = 6;
  localparam logic [CNT_W-1:0] CNT_HUNT  = 6'd0;
  localparam logic [CNT_W-1:0] CNT_SYNC1 = 6'd1;
  localparam logic [CNT_W-1:0] CNT_FIRST = 6'd2;
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(FRAME_LEN - 1);

  // One decoded frame
  typedef struct packed {
    logic               frame_ok;
    logic [31:0]        accel_x_bits;
    logic [31:0]        accel_y_bits;
    logic [31:0]        accel_z_bits;
    logic [31:0]        gyro_x_bits;
    logic [31:0]        gyro_y_bits;
    logic [31:0]        gyro_z_bits;
    logic [63:0]        stick_values;
    logic [15:0]        button_bits;
    logic [63:0]        battery_bits;
    logic signed [7:0]  rssi_dbm;
  } frame_t;

  // Control from the sync/count tracker to the datapath
  typedef struct packed {
    logic shift;         // payload beat: advance the cell chain
    logic done;          // checksum beat accepted: load the result
    logic ok;            // checksum matched on the done beat
    logic last_pending;  // next beat is the checksum beat
  } ctrl_t;

endpackage

FILE: hdl/shd_if.sv
interface shd_rx_if;
  import shd_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface shd_frame_if;
  import shd_pkg::*;

  logic   valid;
  logic   ready;
  frame_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/shd_cell.sv
module shd_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d_in,
  output logic [7:0] q
);

  logic [7:0] q_r;

  // Take the byte on d_in on every payload beat
  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

FILE: hdl/shd_ctrl.sv
module shd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  output shd_pkg::ctrl_t  ctl
);
  import shd_pkg::*;

  typedef enum logic [1:0] {
    HUNT,
    WAIT_CC,
    COLLECT
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             in_body;

  assign in_body = (count_r < CNT_LAST);

  // Work out the next phase, count and checksum for this beat
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    xor_nxt   = xor_r;
    ctl       = '0;
    ctl.last_pending = (phase_r == COLLECT) && !in_body;
    if (accept) begin
      case (phase_r)
        WAIT_CC: begin
          if (rx_byte == SYNC_SECOND) begin
            phase_nxt = COLLECT;
            count_nxt = CNT_FIRST;
            xor_nxt   = '0;
          end else if (rx_byte == SYNC_FIRST) begin
            phase_nxt = WAIT_CC;
            count_nxt = CNT_SYNC1;
          end else begin
            phase_nxt = HUNT;
            count_nxt = CNT_HUNT;
          end
        end
        COLLECT: begin
          if (in_body) begin
            ctl.shift = 1'b1;
            xor_nxt   = xor_r ^ rx_byte;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ctl.done  = 1'b1;
            ctl.ok    = (xor_r == rx_byte);
            phase_nxt = HUNT;
            count_nxt = CNT_HUNT;
            xor_nxt   = '0;
          end
        end
        default: begin
          if (rx_byte == SYNC_FIRST) begin
            phase_nxt = WAIT_CC;
            count_nxt = CNT_SYNC1;
          end else begin
            phase_nxt = HUNT;
            count_nxt = CNT_HUNT;
          end
        end
      endcase
    end
  end

  // Hold tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= HUNT;
      count_r <= CNT_HUNT;
      xor_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == COLLECT) |-> (count_r >= CNT_FIRST && count_r <= CNT_LAST))
    else $error("frame byte count out of range while collecting");

  a_done_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |=> (phase_r == HUNT && count_r == CNT_HUNT && xor_r == '0))
    else $error("tracker did not rearm after checksum beat");

  a_shift_collect: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.shift || ctl.done) |-> (phase_r == COLLECT && accept))
    else $error("chain or result moved outside a frame");

endmodule

FILE: hdl/sync_header_frame_deframer.sv
// Sync-header frame deframer.
// in_ch carries one received byte per beat. The block hunts for the pair
// 0xBB 0xCC (a repeated 0xBB restarts the pair, any other byte drops it),
// then takes 44 more bytes with no resync inside the frame. Bytes 2..44 ripple
// through a row of 43 byte cells while a running XOR is kept; byte 45 is the
// checksum. On that beat one frame is loaded into the out_ch register with
// its little-endian fields and frame_ok set when the XOR matches.
// Throughput: one byte per cycle outside the stall below, set by the cell shift and XOR.
// Result: the result is valid the cycle after the checksum beat is accepted.
// Stall: in_ch.ready drops only while the checksum beat is next and the
// previous result still waits on out_ch; all other bytes flow meanwhile.
// Reset (rst_n low, synchronous): returns to hunting and empties the output
// register; the cell contents are left as they are, since every frame
// refills all 43 cells before its result is loaded.
module sync_header_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  shd_rx_if.sink      in_ch,
  shd_frame_if.source out_ch
);
  import shd_pkg::*;

  ctrl_t                  ctl;
  logic                   accept;
  logic [7:0]             cell_q [CHAIN_LEN];
  logic [8*CHAIN_LEN-1:0] frame_bytes;
  logic                   out_valid_r;
  frame_t                 out_data_r;

  // Hold input only when the checksum beat would overwrite a waiting result
  assign in_ch.ready = !(ctl.last_pending && out_valid_r && !out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  shd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .ctl     (ctl)
  );

  // Row of byte cells: cell 0 takes the newest byte
  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      shd_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .d_in  (in_ch.rx_byte),
        .q     (cell_q[i])
      );
    end else begin : g_body
      shd_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .d_in  (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
    // frame byte 2 sits in the last cell, byte 44 in cell 0
    assign frame_bytes[8*i +: 8] = cell_q[CHAIN_LEN-1-i];
  end

  // Load the result register on the checksum beat, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      out_data_r.frame_ok     <= ctl.ok;
      out_data_r.accel_x_bits <= frame_bytes[0   +: 32];
      out_data_r.accel_y_bits <= frame_bytes[32  +: 32];
      out_data_r.accel_z_bits <= frame_bytes[64  +: 32];
      out_data_r.gyro_x_bits  <= frame_bytes[96  +: 32];
      out_data_r.gyro_y_bits  <= frame_bytes[128 +: 32];
      out_data_r.gyro_z_bits  <= frame_bytes[160 +: 32];
      out_data_r.stick_values <= frame_bytes[192 +: 64];
      out_data_r.button_bits  <= frame_bytes[256 +: 16];
      out_data_r.battery_bits <= frame_bytes[272 +: 64];
      out_data_r.rssi_dbm     <= $signed(frame_bytes[336 +: 8]);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |-> !(out_valid_r && !out_ch.ready))
    else $error("result loaded over a waiting result");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |=> out_valid_r)
    else $error("checksum beat produced no result");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import shd_pkg::*;

  localparam int unsigned STORE_DEPTH = FRAME_LEN - 2;
  localparam int unsigned PAYLOAD_LEN = FRAME_LEN - 3;
  localparam int unsigned RANDOM_BYTES = 1200;
  localparam int unsigned MIN_FRAMES = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES = 500;

  // Predicted position of the deframer in the byte stream
  typedef enum logic [1:0] {
    HUNT_FIRST = 2'd0,
    WAIT_SECOND = 2'd1,
    COLLECT = 2'd2
  } hunt_phase_t;

  // Payload patterns for generated frames
  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_SYNC
  } fill_t;

  logic clk;
  logic rst_n;

  shd_rx_if rx_ch ();
  shd_frame_if frame_ch ();

  sync_header_frame_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (rx_ch),
    .out_ch (frame_ch)
  );

  // Predictor state
  hunt_phase_t      pred_phase;
  logic [CNT_W-1:0] pred_count;
  logic [7:0]       pred_xor;
  logic [7:0]       pred_store [STORE_DEPTH];

  logic [7:0] byte_queue [$];
  frame_t     frames_due [$];

  logic in_taken;
  int   mismatch_count;
  int   frames_checked;
  int   good_frames;
  int   bytes_taken;
  int   cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Little-endian word from the predicted store, pos is the frame byte position
  function automatic logic [63:0] store_le(input int pos, input int nbytes);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < nbytes; i++) v[8*i +: 8] = pred_store[pos - 2 + i];
    return v;
  endfunction

  // Advance the predicted deframer by one byte, queue a frame on the checksum byte
  task automatic predict_byte(input logic [7:0] b);
    frame_t f;
    case (pred_phase)
      WAIT_SECOND: begin
        if (b == SYNC_SECOND) begin
          pred_phase = COLLECT;
          pred_count = CNT_FIRST;
          pred_xor = 8'h00;
        end else if (b == SYNC_FIRST) begin
          pred_phase = WAIT_SECOND;
          pred_count = CNT_SYNC1;
        end else begin
          pred_phase = HUNT_FIRST;
          pred_count = CNT_HUNT;
        end
      end
      COLLECT: begin
        if (pred_count < CNT_LAST) begin
          pred_store[int'(pred_count) - 2] = b;
          pred_xor ^= b;
          pred_count = pred_count + 1'b1;
        end else begin
          pred_store[STORE_DEPTH - 1] = b;
          f.frame_ok     = (pred_xor == b);
          f.accel_x_bits = 32'(store_le(2, 4));
          f.accel_y_bits = 32'(store_le(6, 4));
          f.accel_z_bits = 32'(store_le(10, 4));
          f.gyro_x_bits  = 32'(store_le(14, 4));
          f.gyro_y_bits  = 32'(store_le(18, 4));
          f.gyro_z_bits  = 32'(store_le(22, 4));
          f.stick_values = store_le(26, 8);
          f.button_bits  = 16'(store_le(34, 2));
          f.battery_bits = store_le(36, 8);
          f.rssi_dbm     = 8'(store_le(44, 1));
          frames_due.push_back(f);
          pred_phase = HUNT_FIRST;
          pred_count = CNT_HUNT;
          pred_xor = 8'h00;
        end
      end
      default: begin
        // the unused phase code acts as hunting
        if (b == SYNC_FIRST) begin
          pred_phase = WAIT_SECOND;
          pred_count = CNT_SYNC1;
        end else begin
          pred_phase = HUNT_FIRST;
          pred_count = CNT_HUNT;
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH at frame %0d, %s: expected %h, got %h",
               frames_checked, what, want, got);
  endtask

  task automatic check_frame(input frame_t want, input frame_t got);
    if (got.frame_ok !== want.frame_ok)
      note_mismatch("frame_ok", 64'(want.frame_ok), 64'(got.frame_ok));
    if (got.accel_x_bits !== want.accel_x_bits)
      note_mismatch("accel_x_bits", 64'(want.accel_x_bits), 64'(got.accel_x_bits));
    if (got.accel_y_bits !== want.accel_y_bits)
      note_mismatch("accel_y_bits", 64'(want.accel_y_bits), 64'(got.accel_y_bits));
    if (got.accel_z_bits !== want.accel_z_bits)
      note_mismatch("accel_z_bits", 64'(want.accel_z_bits), 64'(got.accel_z_bits));
    if (got.gyro_x_bits !== want.gyro_x_bits)
      note_mismatch("gyro_x_bits", 64'(want.gyro_x_bits), 64'(got.gyro_x_bits));
    if (got.gyro_y_bits !== want.gyro_y_bits)
      note_mismatch("gyro_y_bits", 64'(want.gyro_y_bits), 64'(got.gyro_y_bits));
    if (got.gyro_z_bits !== want.gyro_z_bits)
      note_mismatch("gyro_z_bits", 64'(want.gyro_z_bits), 64'(got.gyro_z_bits));
    if (got.stick_values !== want.stick_values)
      note_mismatch("stick_values", want.stick_values, got.stick_values);
    if (got.button_bits !== want.button_bits)
      note_mismatch("button_bits", 64'(want.button_bits), 64'(got.button_bits));
    if (got.battery_bits !== want.battery_bits)
      note_mismatch("battery_bits", want.battery_bits, got.battery_bits);
    if (got.rssi_dbm !== want.rssi_dbm)
      note_mismatch("rssi_dbm", 64'(unsigned'(want.rssi_dbm)),
                    64'(unsigned'(got.rssi_dbm)));
  endtask

  // Queue sync pair, 43 payload bytes and a checksum byte
  task automatic queue_frame(input fill_t fill, input bit good_sum);
    logic [7:0] b;
    logic [7:0] sum;
    sum = 8'h00;
    byte_queue.push_back(SYNC_FIRST);
    byte_queue.push_back(SYNC_SECOND);
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        FILL_SYNC: begin
          case ($urandom_range(0, 4))
            0: b = SYNC_FIRST;
            1: b = SYNC_SECOND;
            2: b = 8'h00;
            3: b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
          endcase
        end
        default: b = 8'($urandom_range(0, 255));
      endcase
      sum ^= b;
      byte_queue.push_back(b);
    end
    byte_queue.push_back(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
  endtask

  // Stimulus: directed cases, then mostly frames with noise between them
  initial begin
    int frames_queued;
    int pick;
    rst_n = 1'b0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    frame_ch.ready = 1'b0;

    // noise extremes, then a sync byte dropped by a plain byte
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'hFF);
    byte_queue.push_back(SYNC_SECOND);
    byte_queue.push_back(SYNC_FIRST);
    byte_queue.push_back(8'h00);
    // repeated first sync byte restarts the pair
    byte_queue.push_back(SYNC_FIRST);
    queue_frame(FILL_ZERO, 1'b1);
    queue_frame(FILL_ONES, 1'b0);
    queue_frame(FILL_SYNC, 1'b1);
    queue_frame(FILL_ONES, 1'b1);
    queue_frame(FILL_RANDOM, 1'b0);
    frames_queued = 5;

    while (byte_queue.size() < RANDOM_BYTES || frames_queued < MIN_FRAMES) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 3) == 0) byte_queue.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0) byte_queue.push_back(SYNC_FIRST);
        case ($urandom_range(0, 19))
          0: queue_frame(FILL_ZERO, $urandom_range(0, 1) != 0);
          1: queue_frame(FILL_ONES, $urandom_range(0, 1) != 0);
          2, 3: queue_frame(FILL_SYNC, $urandom_range(0, 3) != 0);
          default: queue_frame(FILL_RANDOM, $urandom_range(0, 9) < 7);
        endcase
        frames_queued++;
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) byte_queue.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        // broken sync pair
        byte_queue.push_back(SYNC_FIRST);
        pick = $urandom_range(0, 255);
        byte_queue.push_back(pick == SYNC_SECOND ? 8'h00 : 8'(pick));
      end else begin
        repeat ($urandom_range(2, 4)) byte_queue.push_back(SYNC_FIRST);
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // drain: everything sent, every frame seen
    @(negedge clk);
    while (byte_queue.size() != 0 || rx_ch.valid || frames_due.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d bytes; checked %0d frames (%0d good checksum, %0d corrupt).",
             bytes_taken, frames_checked, good_frames, frames_checked - good_frames);
    $display("Covered sync restarts and drops, sync bytes inside frames, receiver holds.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Byte driver: offer queued bytes at the falling edge with random gaps
  int sender_gap;
  int burst_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      rx_ch.valid <= 1'b0;
      sender_gap = 0;
      burst_left = 0;
    end else if (!rx_ch.valid || in_taken) begin
      if (sender_gap > 0) begin
        sender_gap--;
        rx_ch.valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= byte_queue.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          case ($urandom_range(0, 19))
            0, 1, 2: burst_left = $urandom_range(20, 150);
            3: sender_gap = $urandom_range(10, 40);
            4, 5, 6, 7, 8, 9: sender_gap = $urandom_range(1, 3);
            default: sender_gap = 0;
          endcase
        end
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // Frame receiver: random ready pattern plus two long holds
  int  ready_left;
  int  hold_left;
  int  holds_started;
  bit  ready_level;
  always @(negedge clk) begin
    if (!rst_n) begin
      frame_ch.ready <= 1'b0;
      ready_left = 0;
      hold_left = 0;
      holds_started = 0;
      ready_level = 1'b0;
    end else begin
      if ((holds_started == 0 && frames_checked >= 3) ||
          (holds_started == 1 && frames_checked >= 20)) begin
        hold_left = HOLD_CYCLES;
        holds_started++;
      end
      if (hold_left > 0) begin
        hold_left--;
        frame_ch.ready <= 1'b0;
      end else begin
        if (ready_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              ready_level = 1'b1;
              ready_left = $urandom_range(1, 40);
            end
            5: begin
              ready_level = 1'b0;
              ready_left = $urandom_range(10, 60);
            end
            default: begin
              ready_level = 1'b0;
              ready_left = $urandom_range(1, 3);
            end
          endcase
        end
        ready_left--;
        frame_ch.ready <= ready_level;
      end
    end
  end

  // Monitor: check accepted frames, then feed accepted bytes to the predictor
  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      pred_phase = HUNT_FIRST;
      pred_count = CNT_HUNT;
      pred_xor = 8'h00;
    end else begin
      in_taken <= rx_ch.valid && rx_ch.ready;
      if (frame_ch.valid && frame_ch.ready) begin
        if (frames_due.size() == 0) begin
          note_mismatch("frame with none due", 64'h0, 64'(frame_ch.data.frame_ok));
        end else begin
          want = frames_due.pop_front();
          check_frame(want, frame_ch.data);
          if (want.frame_ok) good_frames++;
        end
        frames_checked++;
      end
      if (rx_ch.valid && rx_ch.ready) begin
        predict_byte(rx_ch.rx_byte);
        bytes_taken++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d frames still due", cycle_count,
               frames_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

FILE: filelist.f
hdl/shd_pkg.sv
hdl/shd_if.sv
hdl/shd_cell.sv
hdl/shd_ctrl.sv
hdl/sync_header_frame_deframer.sv
tb/sv/tb.sv
